FILE: rtl/bb3_pkg.sv
package bb3_pkg;

   // geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // field and counter widths
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int LW_W    = 11;
   localparam int FH_W    = 13;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int CSUM_W  = CH_W + 2;
   localparam int SUM_W   = CH_W + 4;
   localparam int CCNT_W  = 2;
   localparam int CNT_W   = 4;

   // csr port
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;
   localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = LW_W'(64);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(64);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // reciprocal divide by 2*count
   localparam int DIV_IN_W    = SUM_W + 1;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 19;
   localparam int PROD_W      = DIV_IN_W + RECIP_W;

   // one stored column of the window
   typedef struct packed {
      logic [CSUM_W-1:0] sum_r;
      logic [CSUM_W-1:0] sum_g;
      logic [CSUM_W-1:0] sum_b;
      logic [CCNT_W-1:0] count;
   } bb3_col_type;

   // window sums for one result
   typedef struct packed {
      logic [SUM_W-1:0] sum_r;
      logic [SUM_W-1:0] sum_g;
      logic [SUM_W-1:0] sum_b;
      logic [CNT_W-1:0] count;
      logic             frame_end;
   } bb3_entry_type;

   typedef struct packed {
      logic          valid;
      bb3_entry_type entry;
   } bb3_push_type;

   typedef struct packed {
      logic          valid;
      bb3_entry_type entry;
   } bb3_head_type;

   // ceil(2^19 / (2*count)), exact over the sum range
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd2:    r = RECIP_W'(131072);
         4'd3:    r = RECIP_W'(87382);
         4'd4:    r = RECIP_W'(65536);
         4'd5:    r = RECIP_W'(52429);
         4'd6:    r = RECIP_W'(43691);
         4'd7:    r = RECIP_W'(37450);
         4'd8:    r = RECIP_W'(32768);
         4'd9:    r = RECIP_W'(29128);
         default: r = RECIP_W'(262144);
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/bb3_req_if.sv
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, output command, output in_red, output in_green,
                   output in_blue, input ready);
   modport sink (input valid, input command, input in_red, input in_green,
                 input in_blue, output ready);
endinterface

FILE: rtl/bb3_rsp_if.sv
interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_end;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output frame_end, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input frame_end, output ready);
endinterface

FILE: rtl/box_blur_3x3_top.sv
// ordering: a pixel's result leaves with the transaction line_width+1 positions later,
// passing through the stage-one, queue, product and output registers
// throughput: one transaction per cycle sustained while results are taken, set by the single
// write port of the line store and the column update; a held result stalls after four queued
// reset: synchronous, clears positions, queue and pipeline; geometry returns to 64 x 64
module box_blur_3x3_top (
   input  logic                       clock,
   input  logic                       reset,
   bb3_req_if.sink                    req_bus,
   bb3_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bb3_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [bb3_pkg::DATA_W-1:0] csr_pwdata,
   output logic [bb3_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import bb3_pkg::*;

   logic [LW_W-1:0]   line_width_ff, width_eff;
   logic [FH_W-1:0]   frame_height_ff, height_eff;
   logic              wr;
   bb3_push_type      push;
   bb3_head_type      head;
   logic              pop;
   logic [QCNT_W-1:0] q_count;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (wr) begin
         case (csr_paddr[2])
            REG_LINE_WIDTH:   line_width_ff   <= csr_pwdata[LW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_paddr[2])
         REG_LINE_WIDTH:   csr_prdata = DATA_W'(line_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamped geometry
   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = LW_W'(1);
      end else if (line_width_ff > LW_W'(MAX_WIDTH)) begin
         width_eff = LW_W'(MAX_WIDTH);
      end else begin
         width_eff = line_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_eff = FH_W'(1);
      end else if (frame_height_ff > FH_W'(MAX_HEIGHT)) begin
         height_eff = FH_W'(MAX_HEIGHT);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   bb3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .restart    (wr),
      .q_count    (q_count),
      .push       (push)
   );

   bb3_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   bb3_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );
endmodule

FILE: rtl/bb3_ram.sv
module bb3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/bb3_front.sv
module bb3_front (
   input  logic                      clock,
   input  logic                      reset,
   bb3_req_if.sink                   req,
   input  logic [bb3_pkg::LW_W-1:0]  width_eff,
   input  logic [bb3_pkg::FH_W-1:0]  height_eff,
   input  logic                      restart,
   input  logic [bb3_pkg::QCNT_W-1:0] q_count,
   output bb3_pkg::bb3_push_type     push
);
   import bb3_pkg::*;

   logic [COL_W-1:0] cs_ff, cs_in;
   logic [ROW_W-1:0] rs_ff, rs_in;
   logic             in_frame, ignore, step, accept;
   logic [ROW_W-1:0] h_plus;

   // stage one registers
   logic             s1_valid_ff, s1_prod_ff, s1_last_ff;
   logic [COL_W-1:0] s1_cs_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_top_ok_ff, s1_mid_ok_ff, s1_bot_ok_ff;
   logic             s1_left_ok_ff, s1_right_ok_ff;
   logic             byp_hit_ff;
   logic [2*PIX_W-1:0] byp_data_ff;

   logic [2*PIX_W-1:0] ram_q, line;
   logic [PIX_W-1:0]   mid, top;
   bb3_col_type        col_new, col_l_ff, col_m_ff, col_l, col_r;

   // flow control: room for the transaction in stage one as well
   assign req.ready = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid_ff))
                      < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept   = req.valid && req.ready;
   assign in_frame = rs_ff < ROW_W'(height_eff);
   assign ignore   = in_frame && req.command;
   assign step     = accept && !ignore;
   assign h_plus   = ROW_W'(height_eff) + ROW_W'(1);

   // stream position
   always_comb begin
      cs_in = cs_ff;
      rs_in = rs_ff;
      if (restart) begin
         cs_in = '0;
         rs_in = '0;
      end else if (step) begin
         if (rs_ff == h_plus) begin
            cs_in = '0;
            rs_in = '0;
         end else if (({1'b0, cs_ff} + LW_W'(1)) == width_eff) begin
            cs_in = '0;
            rs_in = rs_ff + ROW_W'(1);
         end else begin
            cs_in = cs_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff       <= '0;
         rs_ff       <= '0;
         s1_valid_ff <= 1'b0;
         byp_hit_ff  <= 1'b0;
      end else begin
         cs_ff       <= cs_in;
         rs_ff       <= rs_in;
         s1_valid_ff <= step;
         if (step) begin
            byp_hit_ff <= s1_valid_ff && (s1_cs_ff == cs_ff);
         end
      end
   end

   // capture the transaction for stage one
   always_ff @(posedge clock) begin
      if (step) begin
         s1_cs_ff       <= cs_ff;
         s1_pix_ff      <= {req.in_red, req.in_green, req.in_blue};
         s1_top_ok_ff   <= rs_ff >= ROW_W'(2);
         s1_mid_ok_ff   <= (rs_ff >= ROW_W'(1)) && (rs_ff <= ROW_W'(height_eff));
         s1_bot_ok_ff   <= in_frame;
         s1_prod_ff     <= (rs_ff >= ROW_W'(2)) ||
                           ((rs_ff == ROW_W'(1)) && (cs_ff != '0));
         s1_left_ok_ff  <= !((cs_ff == COL_W'(1)) ||
                             ((cs_ff == '0) && (width_eff == LW_W'(1))));
         s1_right_ok_ff <= cs_ff != '0;
         s1_last_ff     <= rs_ff == h_plus;
         byp_data_ff    <= {s1_pix_ff, mid};
      end
   end

   // two previous rows per column
   bb3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_cs_ff),
      .wr_data ({s1_pix_ff, mid}),
      .rd_en   (step),
      .rd_addr (cs_ff),
      .rd_data (ram_q)
   );

   // forward a write that raced the read
   assign line = byp_hit_ff ? byp_data_ff : ram_q;
   assign mid  = line[2*PIX_W-1:PIX_W];
   assign top  = line[PIX_W-1:0];

   // new column sums, rows outside the frame masked
   always_comb begin
      logic [PIX_W-1:0] t, m, b;
      t = s1_top_ok_ff ? top : '0;
      m = s1_mid_ok_ff ? mid : '0;
      b = s1_bot_ok_ff ? s1_pix_ff : '0;
      col_new.sum_r = CSUM_W'(t[23:16]) + CSUM_W'(m[23:16]) + CSUM_W'(b[23:16]);
      col_new.sum_g = CSUM_W'(t[15:8]) + CSUM_W'(m[15:8]) + CSUM_W'(b[15:8]);
      col_new.sum_b = CSUM_W'(t[7:0]) + CSUM_W'(m[7:0]) + CSUM_W'(b[7:0]);
      col_new.count = CCNT_W'(s1_top_ok_ff) + CCNT_W'(s1_mid_ok_ff)
                      + CCNT_W'(s1_bot_ok_ff);
   end

   // column window shift
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         col_l_ff <= col_m_ff;
         col_m_ff <= col_new;
      end
   end

   // window totals, columns outside the frame masked
   assign col_l = s1_left_ok_ff ? col_l_ff : '0;
   assign col_r = s1_right_ok_ff ? col_new : '0;

   always_comb begin
      push.valid           = s1_valid_ff && s1_prod_ff;
      push.entry.sum_r     = SUM_W'(col_l.sum_r) + SUM_W'(col_m_ff.sum_r) + SUM_W'(col_r.sum_r);
      push.entry.sum_g     = SUM_W'(col_l.sum_g) + SUM_W'(col_m_ff.sum_g) + SUM_W'(col_r.sum_g);
      push.entry.sum_b     = SUM_W'(col_l.sum_b) + SUM_W'(col_m_ff.sum_b) + SUM_W'(col_r.sum_b);
      push.entry.count     = CNT_W'(col_l.count) + CNT_W'(col_m_ff.count) + CNT_W'(col_r.count);
      push.entry.frame_end = s1_last_ff;
   end
endmodule

FILE: rtl/bb3_queue.sv
module bb3_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  bb3_pkg::bb3_push_type      push,
   input  logic                       pop,
   output bb3_pkg::bb3_head_type      head,
   output logic [bb3_pkg::QCNT_W-1:0] count
);
   import bb3_pkg::*;

   bb3_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push.valid) - QCNT_W'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end
endmodule

FILE: rtl/bb3_back.sv
module bb3_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bb3_pkg::bb3_head_type head,
   output logic                  pop,
   bb3_rsp_if.source             rsp
);
   import bb3_pkg::*;

   logic              advance;
   logic              a_valid_ff, out_valid_ff;
   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic              a_end_ff, out_end_ff;
   logic [CH_W-1:0]   out_r_ff, out_g_ff, out_b_ff;
   logic [RECIP_W-1:0] r;

   assign advance = !out_valid_ff || rsp.ready;
   assign pop     = advance && head.valid;
   assign r       = recip(head.entry.count);

   // multiply (2*sum + count) by the reciprocal of 2*count
   function automatic logic [PROD_W-1:0] scale(input logic [SUM_W-1:0] sum,
                                               input logic [CNT_W-1:0] count,
                                               input logic [RECIP_W-1:0] k);
      logic [DIV_IN_W-1:0] x;
      x = DIV_IN_W'({sum, 1'b0}) + DIV_IN_W'(count);
      return PROD_W'(x) * PROD_W'(k);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= pop;
         out_valid_ff <= a_valid_ff;
      end
   end

   // product stage and output register
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff  <= scale(head.entry.sum_r, head.entry.count, r);
         prod_g_ff  <= scale(head.entry.sum_g, head.entry.count, r);
         prod_b_ff  <= scale(head.entry.sum_b, head.entry.count, r);
         a_end_ff   <= head.entry.frame_end;
         out_r_ff   <= prod_r_ff[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
         out_g_ff   <= prod_g_ff[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
         out_b_ff   <= prod_b_ff[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
         out_end_ff <= a_end_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_red   = out_r_ff;
   assign rsp.out_green = out_g_ff;
   assign rsp.out_blue  = out_b_ff;
   assign rsp.frame_end = out_end_ff;
endmodule

FILE: tb/sv/bb3_blur_checker.sv
// watches both channels, predicts the blurred pixel stream and compares it
module bb3_blur_checker (
   input  logic        clock,
   input  logic        reset,
   bb3_req_if.sink     req_mon,
   bb3_rsp_if.sink     rsp_mon,
   input  logic        cfg_we,
   input  logic        cfg_sel,
   input  logic [31:0] cfg_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bb3_pkg::*;

   localparam int RING = 2 * MAX_WIDTH + 3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pixel_type;

   logic [LW_W-1:0] width_reg;
   logic [FH_W-1:0] height_reg;
   logic [23:0]     pixel_ring [RING];
   int unsigned     stream_pos;
   blur_pixel_type  blur_expected [$];

   function automatic logic [7:0] rounded_mean(int unsigned sum, int unsigned cnt);
      return 8'((2 * sum + cnt) / (2 * cnt));
   endfunction

   // advance the model by one accepted transaction
   task automatic blur_step(input logic cmd, input logic [23:0] pix);
      int unsigned w, h, total, q, cnt, sr, sg, sb, k;
      int qr, qc, nr, nc;
      logic [23:0] p;
      blur_pixel_type res;
      w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      total = w * h;
      if (stream_pos < total) begin
         if (cmd) return;
         pixel_ring[stream_pos % RING] = pix;
      end
      if (stream_pos >= w + 1) begin
         q = stream_pos - w - 1;
         qr = q / w;
         qc = q % w;
         sr = 0; sg = 0; sb = 0; cnt = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               nr = qr + dr;
               nc = qc + dc;
               if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
                  k = nr * w + nc;
                  p = pixel_ring[k % RING];
                  sr += p[23:16];
                  sg += p[15:8];
                  sb += p[7:0];
                  cnt++;
               end
            end
         end
         res.red = rounded_mean(sr, cnt);
         res.green = rounded_mean(sg, cnt);
         res.blue = rounded_mean(sb, cnt);
         res.frame_end = (q == total - 1);
         blur_expected.push_back(res);
      end
      if (stream_pos >= total + w) stream_pos = 0;
      else stream_pos++;
   endtask

   assign pending_count = blur_expected.size();

   // monitor and compare
   always @(posedge clock) begin
      blur_pixel_type exp_pix;
      if (reset) begin
         width_reg <= LINE_WIDTH_RESET;
         height_reg <= FRAME_HEIGHT_RESET;
         stream_pos = 0;
         blur_expected.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (blur_expected.size() == 0) begin
               $error("unexpected result transaction");
               fail_count <= fail_count + 1;
            end else begin
               exp_pix = blur_expected.pop_front();
               if (rsp_mon.out_red !== exp_pix.red ||
                   rsp_mon.out_green !== exp_pix.green ||
                   rsp_mon.out_blue !== exp_pix.blue ||
                   rsp_mon.frame_end !== exp_pix.frame_end) begin
                  if (rsp_mon.out_red !== exp_pix.red)
                     $error("out_red exp %0d got %0d", exp_pix.red, rsp_mon.out_red);
                  if (rsp_mon.out_green !== exp_pix.green)
                     $error("out_green exp %0d got %0d", exp_pix.green, rsp_mon.out_green);
                  if (rsp_mon.out_blue !== exp_pix.blue)
                     $error("out_blue exp %0d got %0d", exp_pix.blue, rsp_mon.out_blue);
                  if (rsp_mon.frame_end !== exp_pix.frame_end)
                     $error("frame_end exp %0d got %0d", exp_pix.frame_end,
                            rsp_mon.frame_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            blur_step(req_mon.command, {req_mon.in_red, req_mon.in_green, req_mon.in_blue});
         // register write restarts the frame
         if (cfg_we) begin
            if (cfg_sel == REG_LINE_WIDTH) width_reg <= cfg_data[LW_W-1:0];
            else height_reg <= cfg_data[FH_W-1:0];
            stream_pos = 0;
         end
      end
   end
endmodule

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bb3_pkg::*;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending_count;
   bit quiet_mode = 1'b0;
   bit hold_rsp = 1'b0;
   int cur_width = 64, cur_height = 64;

   bb3_req_if req_bus ();
   bb3_rsp_if rsp_bus ();

   box_blur_3x3_top uut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   bb3_blur_checker blur_check (
      .clock(clock), .reset(reset), .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_sel(csr_paddr[2]), .cfg_data(csr_pwdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #1 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_PIXEL;
      req_bus.in_red = '0;
      req_bus.in_green = '0;
      req_bus.in_blue = '0;
      rsp_bus.ready = 1'b0;
   end

   // timeout
   initial begin
      #4000000;
      $display("box_blur_3x3_top test failed");
      $finish;
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      int gap;
      if (!reset) begin
         if (hold_rsp) rsp_bus.ready <= 1'b0;
         else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else rsp_bus.ready <= 1'b1;
      end
   end

   task automatic csr_write(input logic sel, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // offer one transaction and wait for acceptance
   task automatic send_item(input logic cmd, input logic [7:0] r, g, b, input bit gaps);
      if (gaps && !quiet_mode && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.in_red <= r;
      req_bus.in_green <= g;
      req_bus.in_blue <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic go_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      go_idle();
      csr_write(REG_LINE_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      cur_width = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      cur_height = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
   endtask

   // one frame of random pixels plus its drain, with some noise
   task automatic random_frame(output int sent);
      int n;
      n = cur_width * cur_height + cur_width + 1;
      sent = 0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 30) == 0) begin
            send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            sent++;
            if (i >= cur_width * cur_height) continue;
         end
         send_item(i < cur_width * cur_height ? CMD_PIXEL : ($urandom_range(0, 3) == 0 ?
                   CMD_PIXEL : CMD_DRAIN), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
         sent++;
      end
   endtask

   initial begin
      int sent, total;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: 2x2 frame with extreme values
      set_geometry(2, 2);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(CMD_PIXEL, 8'hff, 8'h00, 8'hff, 1'b0);
      send_item(CMD_PIXEL, 8'h00, 8'hff, 8'h00, 1'b0);
      send_item(CMD_PIXEL, 8'hff, 8'hff, 8'hff, 1'b0);
      send_item(CMD_PIXEL, 8'h01, 8'h80, 8'h7f, 1'b0);
      send_item(CMD_PIXEL, 8'haa, 8'h55, 8'haa, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      // clamped geometry: zero sizes act as 1x1
      set_geometry(0, 0);
      send_item(CMD_PIXEL, 8'hfe, 8'h01, 8'h80, 1'b0);
      send_item(CMD_PIXEL, 8'h10, 8'h20, 8'h30, 1'b0);
      send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0);
      // register write mid frame restarts it
      set_geometry(3, 3);
      send_item(CMD_PIXEL, 8'h11, 8'h22, 8'h33, 1'b0);
      send_item(CMD_PIXEL, 8'h44, 8'h55, 8'h66, 1'b0);
      set_geometry(3, 1);
      // random frames over several geometries
      total = 0;
      while (total < 600) begin
         case ($urandom_range(0, 4))
            0: set_geometry($urandom_range(1, 3), $urandom_range(1, 3));
            1: set_geometry($urandom_range(1, 12), $urandom_range(1, 8));
            2: set_geometry(1, $urandom_range(1, 20));
            3: set_geometry($urandom_range(8, 40), 1);
            default: ;
         endcase
         random_frame(sent);
         total += sent;
      end
      // long receiver hold while the sender keeps offering
      set_geometry(8, 4);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_frame(sent);
      join
      // widest line once, oversized value clamps; first few results then restart
      set_geometry(2047, 1);
      for (int i = 0; i < cur_width + 6; i++) begin
         send_item(i < cur_width ? CMD_PIXEL : CMD_DRAIN, 8'($urandom), 8'($urandom),
                   8'($urandom), 1'b1);
      end
      set_geometry(1, 8191);
      quiet_mode = 1'b1;
      set_geometry(5, 5);
      random_frame(sent);
      set_geometry(6, 3);
      random_frame(sent);
      go_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("box_blur_3x3_top test passed");
      else $display("box_blur_3x3_top test failed");
      $finish;
   end
endmodule
